FILE: hw/rtl/matrix_multiply_4x4_macros.svh
// Assertion macros used by the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_4X4_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies the consequent in the same cycle.
`define MM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix multiply assertion failed");

// Antecedent implies the consequent in the following cycle.
`define MM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix multiply assertion failed");

`else

`define MM_ASSERT_SAME(label, ante, cons)
`define MM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/mm4x4_pkg.sv
// Types and constants of the 4x4 fixed-point matrix multiply.
package mm4x4_pkg;

    // Matrix order and index widths.
    localparam int N        = 4;
    localparam int IDX_W    = $clog2(N);
    localparam int CNT_W    = 2 * IDX_W;

    // Field width on the ports and the arithmetic width of one element.
    localparam int DATA_W     = 32;
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Product, accumulator and shifted-sum widths.
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int SHR_W  = ACC_W - FRAC_BITS;

    // The row whose word triggers the product, the first and last step, and the last count.
    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(N - 1);
    localparam logic [IDX_W-1:0] K_FIRST  = '0;
    localparam logic [IDX_W-1:0] K_LAST   = IDX_W'(N - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N * N - 1);

    // One row of stored elements.
    typedef logic [N-1:0][ELEM_WIDTH-1:0] row_t;

    // Input word: one row of A and one row of B.
    typedef struct packed {
        logic [IDX_W-1:0]         row_index;
        logic signed [DATA_W-1:0] a_elem_0;
        logic signed [DATA_W-1:0] a_elem_1;
        logic signed [DATA_W-1:0] a_elem_2;
        logic signed [DATA_W-1:0] a_elem_3;
        logic signed [DATA_W-1:0] b_elem_0;
        logic signed [DATA_W-1:0] b_elem_1;
        logic signed [DATA_W-1:0] b_elem_2;
        logic signed [DATA_W-1:0] b_elem_3;
    } operand_t;

    // Output word: one row of the product.
    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic signed [DATA_W-1:0] c_elem_0;
        logic signed [DATA_W-1:0] c_elem_1;
        logic signed [DATA_W-1:0] c_elem_2;
        logic signed [DATA_W-1:0] c_elem_3;
        logic                     row_overflow;
        logic                     last_row;
    } result_t;

    // Tag that travels with each step down the pipeline.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] k;
    } tag_t;

endpackage

FILE: hw/rtl/matrix_multiply_4x4.sv
// Top level of the 4x4 signed fixed-point matrix multiply.
//
//  channel   signals                         direction   meaning
//  input     start, busy, operand            in/out      one row of A and B per word
//  output    result_valid, result            out         one product row per word
//
// A word for rows 0 to 2 is stored and the block stays free.
// The word for row 3 sets busy while a counter walks row i and step k,
// reading row i of A and row k of B from their memories, and four multipliers
// (one per column) feed four accumulators. Each step passes the read registers,
// the product registers and the accumulators; each finished row is then held in
// the result register. Rows come out in order; a new word waits until busy falls.
// Reset clears control only; memory contents are undefined until written.
// The receiver cannot stall: each result row is shown for one cycle.
`include "matrix_multiply_4x4_macros.svh"

module matrix_multiply_4x4 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mm4x4_pkg::operand_t operand,
    output logic                result_valid,
    output mm4x4_pkg::result_t  result
);
    import mm4x4_pkg::*;

    // Row memories of A and B, with registered read data.
    row_t a_mem [N];
    row_t b_mem [N];
    row_t a_rd_reg;
    row_t b_rd_reg;

    logic             accept;
    row_t             a_wr;
    row_t             b_wr;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    tag_t             iss_tag;
    tag_t             s1_tag_reg, s2_tag_reg, s3_tag_reg;

    logic signed [ELEM_WIDTH-1:0] a_sel;
    logic signed [PROD_W-1:0]     prod [N];
    logic signed [PROD_W-1:0]     p_reg [N];
    logic signed [ACC_W-1:0]      acc_reg [N];
    logic signed [ACC_W-1:0]      acc_next [N];

    logic signed [SHR_W-1:0]      shr [N];
    logic signed [ELEM_WIDTH-1:0] sat [N];
    logic [N-1:0]                 ovf;
    logic                         row_done;
    result_t                      res_reg, res_next;
    logic                         rv_reg;

    assign accept = start && !busy_reg;

    // Incoming row, only the low element bits kept.
    always_comb
    begin
        a_wr[0] = operand.a_elem_0[ELEM_WIDTH-1:0];
        a_wr[1] = operand.a_elem_1[ELEM_WIDTH-1:0];
        a_wr[2] = operand.a_elem_2[ELEM_WIDTH-1:0];
        a_wr[3] = operand.a_elem_3[ELEM_WIDTH-1:0];
        b_wr[0] = operand.b_elem_0[ELEM_WIDTH-1:0];
        b_wr[1] = operand.b_elem_1[ELEM_WIDTH-1:0];
        b_wr[2] = operand.b_elem_2[ELEM_WIDTH-1:0];
        b_wr[3] = operand.b_elem_3[ELEM_WIDTH-1:0];
    end

    // Sequencer: busy flag and the row/step counter.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
        else if (accept && operand.row_index == ROW_LAST)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign iss_tag.vld = busy_reg;
    assign iss_tag.row = cnt_reg[CNT_W-1:IDX_W];
    assign iss_tag.k   = cnt_reg[IDX_W-1:0];

    // Memory write on accept; reads run every cycle but are used only while busy blocks writes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_mem[operand.row_index] <= a_wr;
            b_mem[operand.row_index] <= b_wr;
        end
        a_rd_reg <= a_mem[iss_tag.row];
        b_rd_reg <= b_mem[iss_tag.k];
    end

    // Multiply A[i][k] by each element of B row k.
    always_comb
    begin
        a_sel = a_rd_reg[s1_tag_reg.k];
        for (int c = 0; c < N; c++)
        begin
            prod[c] = PROD_W'(a_sel) * PROD_W'($signed(b_rd_reg[c]));
        end
    end

    // Accumulate four products per element at full precision.
    always_comb
    begin
        for (int c = 0; c < N; c++)
        begin
            if (s2_tag_reg.k == K_FIRST)
            begin
                acc_next[c] = ACC_W'(p_reg[c]);
            end
            else
            begin
                acc_next[c] = acc_reg[c] + ACC_W'(p_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < N; c++)
        begin
            p_reg[c] <= prod[c];
            if (s2_tag_reg.vld)
            begin
                acc_reg[c] <= acc_next[c];
            end
        end
    end

    // Pipeline tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            s1_tag_reg <= iss_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            rv_reg     <= row_done;
        end
    end

    // Drop the fraction bits, which floors the value, then saturate to the element width.
    always_comb
    begin
        for (int c = 0; c < N; c++)
        begin
            shr[c] = acc_reg[c][ACC_W-1:FRAC_BITS];
            if (shr[c] > SHR_W'($signed({1'b0, {(ELEM_WIDTH-1){1'b1}}})))
            begin
                sat[c] = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
                ovf[c] = 1'b1;
            end
            else if (shr[c] < SHR_W'($signed({1'b1, {(ELEM_WIDTH-1){1'b0}}})))
            begin
                sat[c] = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
                ovf[c] = 1'b1;
            end
            else
            begin
                sat[c] = shr[c][ELEM_WIDTH-1:0];
                ovf[c] = 1'b0;
            end
        end
    end

    // Result row, sign-extended to the field width.
    assign row_done = s3_tag_reg.vld && s3_tag_reg.k == K_LAST;

    always_comb
    begin
        res_next.out_row      = s3_tag_reg.row;
        res_next.c_elem_0     = DATA_W'(sat[0]);
        res_next.c_elem_1     = DATA_W'(sat[1]);
        res_next.c_elem_2     = DATA_W'(sat[2]);
        res_next.c_elem_3     = DATA_W'(sat[3]);
        res_next.row_overflow = |ovf;
        res_next.last_row     = s3_tag_reg.row == ROW_LAST;
    end

    always_ff @(posedge clk)
    begin
        if (row_done)
        begin
            res_reg <= res_next;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // Checks on sequencing and result spacing.
    `MM_ASSERT_NEXT(a_trigger_busy, accept && operand.row_index == ROW_LAST, busy_reg)
    `MM_ASSERT_NEXT(a_busy_ends, busy_reg && cnt_reg == CNT_LAST, !busy_reg)
    `MM_ASSERT_NEXT(a_row_spacing, rv_reg, !rv_reg)
    `MM_ASSERT_NEXT(a_done_strobe, row_done, rv_reg && res_reg.out_row == $past(s3_tag_reg.row))

endmodule

FILE: tb/mm4x4_checker.sv
// Checker for the 4x4 matrix multiply: mirrors the row stores and predicts each product row.
`timescale 1ns / 1ps

module mm4x4_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  mm4x4_pkg::operand_t operand,
    input  logic                result_valid,
    input  mm4x4_pkg::result_t  result,
    output int                  fault_count,
    output int                  rows_pending,
    output int                  rows_checked,
    output int                  saturated_rows
);
    import mm4x4_pkg::*;

    // Saturation bounds of one element, held at accumulator width.
    localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) << (ELEM_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    // Local copy of the A and B rows, indexed [row][column].
    logic signed [ELEM_WIDTH-1:0] a_rows [N][N];
    logic signed [ELEM_WIDTH-1:0] b_rows [N][N];

    // Product rows predicted but not yet seen on the output.
    result_t product_rows_due [$];

    // Print one line for a fault and count it.
    task automatic report_fault(input string msg);
        $display("%0t ns  checker: %s", $time, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_fault($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    // Store the A and B rows carried by an accepted word.
    task automatic store_rows(input operand_t word);
        a_rows[word.row_index][0] = ELEM_WIDTH'(word.a_elem_0);
        a_rows[word.row_index][1] = ELEM_WIDTH'(word.a_elem_1);
        a_rows[word.row_index][2] = ELEM_WIDTH'(word.a_elem_2);
        a_rows[word.row_index][3] = ELEM_WIDTH'(word.a_elem_3);
        b_rows[word.row_index][0] = ELEM_WIDTH'(word.b_elem_0);
        b_rows[word.row_index][1] = ELEM_WIDTH'(word.b_elem_1);
        b_rows[word.row_index][2] = ELEM_WIDTH'(word.b_elem_2);
        b_rows[word.row_index][3] = ELEM_WIDTH'(word.b_elem_3);
    endtask

    // Multiply the stored matrices and queue the four product rows.
    // Each dot product is summed exactly, floored by the fraction bits
    // and then clamped to the element range.
    task automatic multiply_stores();
        result_t                    row_word;
        logic signed [PROD_W-1:0]   prod;
        logic signed [ACC_W-1:0]    acc;
        logic signed [ACC_W-1:0]    sum_q;
        logic [N-1:0][DATA_W-1:0]   c;
        logic                       sat;
        for (int i = 0; i < N; i++)
        begin
            sat = 1'b0;
            for (int j = 0; j < N; j++)
            begin
                acc = '0;
                for (int k = 0; k < N; k++)
                begin
                    prod = a_rows[i][k] * b_rows[k][j];
                    acc  = acc + prod;
                end
                sum_q = acc >>> FRAC_BITS;
                if (sum_q > SAT_MAX)
                begin
                    sum_q = SAT_MAX;
                    sat   = 1'b1;
                end
                else if (sum_q < SAT_MIN)
                begin
                    sum_q = SAT_MIN;
                    sat   = 1'b1;
                end
                c[j] = sum_q[DATA_W-1:0];
            end
            row_word.out_row      = IDX_W'(i);
            row_word.c_elem_0     = c[0];
            row_word.c_elem_1     = c[1];
            row_word.c_elem_2     = c[2];
            row_word.c_elem_3     = c[3];
            row_word.row_overflow = sat;
            row_word.last_row     = (IDX_W'(i) == ROW_LAST);
            product_rows_due.push_back(row_word);
        end
    endtask

    // Compare one output word against the oldest predicted row.
    task automatic check_row(input result_t got);
        result_t want;
        if (product_rows_due.size() == 0)
        begin
            report_fault($sformatf("product row %0d arrived with nothing expected",
                                   got.out_row));
            return;
        end
        want = product_rows_due.pop_front();
        rows_checked++;
        if (want.row_overflow)
            saturated_rows++;
        check_field($sformatf("row %0d out_row", want.out_row), got.out_row, want.out_row);
        check_field($sformatf("row %0d c_elem_0", want.out_row), got.c_elem_0, want.c_elem_0);
        check_field($sformatf("row %0d c_elem_1", want.out_row), got.c_elem_1, want.c_elem_1);
        check_field($sformatf("row %0d c_elem_2", want.out_row), got.c_elem_2, want.c_elem_2);
        check_field($sformatf("row %0d c_elem_3", want.out_row), got.c_elem_3, want.c_elem_3);
        check_field($sformatf("row %0d row_overflow", want.out_row),
                    got.row_overflow, want.row_overflow);
        check_field($sformatf("row %0d last_row", want.out_row), got.last_row, want.last_row);
    endtask

    // Watch both channels at each rising edge. A result can never stem from a
    // word accepted on the same edge, so results are checked first.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            product_rows_due.delete();
            fault_count    = 0;
            rows_checked   = 0;
            saturated_rows = 0;
            rows_pending   <= 0;
        end
        else
        begin
            if (result_valid)
                check_row(result);
            if (start && !busy)
            begin
                store_rows(operand);
                if (operand.row_index == ROW_LAST)
                    multiply_stores();
            end
            rows_pending <= product_rows_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Top of the matrix multiply testbench: clock, reset, row stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
    import mm4x4_pkg::*;

    // Run length and limits.
    localparam int ITEM_TARGET    = 410;
    localparam int QUIET_TAIL     = 60;
    localparam int TAIL_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT = 1000;

    // Fixed-point values of interest.
    localparam logic [DATA_W-1:0] ONE_Q   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MIN = 32'h8000_0000;

    typedef logic [N-1:0][DATA_W-1:0] quad_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    operand_t operand;
    logic     result_valid;
    result_t  result;

    int fault_count;
    int rows_pending;
    int rows_checked;
    int saturated_rows;
    int words_sent = 0;
    int idle_run   = 0;
    bit quiet      = 1'b0;

    matrix_multiply_4x4 DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand      (operand),
        .result_valid (result_valid),
        .result       (result)
    );

    mm4x4_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operand        (operand),
        .result_valid   (result_valid),
        .result         (result),
        .fault_count    (fault_count),
        .rows_pending   (rows_pending),
        .rows_checked   (rows_checked),
        .saturated_rows (saturated_rows)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin
        wait (idle_run >= WATCHDOG_LIMIT);
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // One element: wide random values, small ones that stay in range, some
    // scaled so products straddle the saturation limits, or a special value.
    function automatic logic [DATA_W-1:0] random_elem();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 5))
                    0:       return NEG_MIN;
                    1:       return POS_MAX;
                    2:       return '0;
                    3:       return '1;
                    4:       return ONE_Q;
                    default: return -ONE_Q;
                endcase
            1, 2, 3: return DATA_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            4, 5:    return DATA_W'($signed($urandom()) >>> $urandom_range(4, 15));
            default: return $urandom();
        endcase
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        for (int j = 0; j < N; j++)
            q[j] = random_elem();
        return q;
    endfunction

    // Hold start high until the word is taken; start is left high so that a
    // following word can go out on the next cycle.
    task automatic send_word(input operand_t word);
        start   <= 1'b1;
        operand <= word;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        words_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every predicted product row has come out.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0)
            @(posedge clk);
    endtask

    // Send one row of A and B, then perhaps idle for a burst.
    task automatic send_row(input logic [IDX_W-1:0] r, input quad_t a, input quad_t b);
        operand_t word;
        word.row_index = r;
        word.a_elem_0  = a[0];
        word.a_elem_1  = a[1];
        word.a_elem_2  = a[2];
        word.a_elem_3  = a[3];
        word.b_elem_0  = b[0];
        word.b_elem_1  = b[1];
        word.b_elem_2  = b[2];
        word.b_elem_3  = b[3];
        send_word(word);
        if (!quiet && words_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 8));
    endtask

    task automatic send_random_row(input logic [IDX_W-1:0] r);
        send_row(r, random_quad(), random_quad());
    endtask

    initial
    begin
        quad_t a;
        quad_t b;
        int    order [3];
        int    pick;
        int    held;

        rst_n   = 1'b0;
        start   = 1'b0;
        operand = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity times B: the product must equal B exactly. This also
        // fills all four rows before any later product.
        for (int r = 0; r < N; r++)
        begin
            a    = '0;
            a[r] = ONE_Q;
            send_row(IDX_W'(r), a, random_quad());
        end
        wait_drained();

        // Largest positive elements everywhere: every element saturates high.
        for (int r = 0; r < N; r++)
            send_row(IDX_W'(r), {N{POS_MAX}}, {N{POS_MAX}});

        // Largest positive times most negative: saturates low.
        for (int r = 0; r < N; r++)
            send_row(IDX_W'(r), {N{POS_MAX}}, {N{NEG_MIN}});

        // Most negative times most negative: the widest sum, saturates high.
        for (int r = 0; r < N; r++)
            send_row(IDX_W'(r), {N{NEG_MIN}}, {N{NEG_MIN}});

        // Tiny negative sums must floor to minus one, not truncate to zero.
        for (int r = 0; r < N; r++)
            send_row(IDX_W'(r), {N{32'hFFFF_FFFF}}, {N{32'h0000_0001}});
        wait_drained();

        // Rewrite row 1 and the last row only; the product uses the rows still held.
        send_random_row(IDX_W'(1));
        send_random_row(ROW_LAST);

        // Random part: mostly complete matrices, with shuffled, partial,
        // broken and noise sequences mixed in.
        while (words_sent < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
                wait_drained();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    for (int r = 0; r < N; r++)
                        send_random_row(IDX_W'(r));
                6:
                begin
                    order = '{0, 1, 2};
                    for (int s = 2; s > 0; s--)
                    begin
                        pick        = $urandom_range(0, s);
                        held        = order[s];
                        order[s]    = order[pick];
                        order[pick] = held;
                    end
                    for (int s = 0; s < 3; s++)
                        send_random_row(IDX_W'(order[s]));
                    send_random_row(ROW_LAST);
                end
                7:
                begin
                    repeat ($urandom_range(1, 2))
                        send_random_row(IDX_W'($urandom_range(0, 2)));
                    send_random_row(ROW_LAST);
                end
                8:
                    repeat ($urandom_range(1, 4))
                        send_random_row(IDX_W'($urandom_range(0, 3)));
                default:
                    for (int r = 0; r <= $urandom_range(0, 2); r++)
                        send_random_row(IDX_W'(r));
            endcase
        end

        // Let the last product rows come out, then let the clock run on for the tail.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d row words; checked %0d product rows, %0d of them saturated.",
                 words_sent, rows_checked, saturated_rows);
        if (fault_count == 0 && rows_pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mm4x4_pkg.sv
hw/rtl/matrix_multiply_4x4.sv
tb/mm4x4_checker.sv
tb/tb.sv
